/* src/s96au_pkg.sv */
// ----------------------------------------------------------------------------
// s96au_pkg
// Shared types and command codes for the 96-bit signed arithmetic unit.
// ----------------------------------------------------------------------------
package s96au_pkg;

    // Command codes carried by each item
    typedef enum logic [2:0] {
        CMD_ADD  = 3'd0,
        CMD_SUB  = 3'd1,
        CMD_MUL  = 3'd2,
        CMD_FMUL = 3'd3,
        CMD_SHL  = 3'd4,
        CMD_SHR  = 3'd5
    } cmd_t;

    localparam int unsigned WORD_W = 96;
    localparam int unsigned LIMB_W = 32;
    localparam int unsigned NLIMB  = WORD_W / LIMB_W;
    localparam int unsigned PROD_W = 2 * LIMB_W;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [LIMB_W-1:0] limb_t;
    typedef logic [PROD_W-1:0] prod_t;

    // Full 3x3 grid of limb products: [i][j] = x limb i times y limb j
    typedef prod_t [NLIMB-1:0][NLIMB-1:0] prod_grid_t;

    // Per-item control that travels alongside the datapath
    typedef struct packed {
        cmd_t cmd;
        logic flip;
    } ctl_t;

endpackage

/* src/s96au_prep.sv */
// ----------------------------------------------------------------------------
// s96au_prep
// Operand preparation stage: add, subtract and shifts finish here; the
// multiplier operands (raw, or magnitudes for the fractional multiply) are
// selected and registered.
// ----------------------------------------------------------------------------
module s96au_prep (
    input  logic                aclk,
    input  logic                en,
    input  s96au_pkg::cmd_t     cmd,
    input  s96au_pkg::word_t    a,
    input  s96au_pkg::word_t    b,
    input  logic [7:0]          shamt,
    output s96au_pkg::ctl_t     ctl_reg,
    output s96au_pkg::word_t    x_reg,
    output s96au_pkg::word_t    y_reg,
    output s96au_pkg::word_t    simple_reg
);

    logic             a_neg;
    logic             b_neg;
    s96au_pkg::word_t a_mag;
    s96au_pkg::word_t b_mag;
    s96au_pkg::word_t b_dbl;
    s96au_pkg::ctl_t  ctl_next;
    s96au_pkg::word_t x_next;
    s96au_pkg::word_t y_next;
    s96au_pkg::word_t simple_next;

    // Magnitudes; the most negative value stays as its own pattern
    always_comb begin
        a_neg = a[s96au_pkg::WORD_W-1];
        b_neg = b[s96au_pkg::WORD_W-1];
        a_mag = a_neg ? (~a + s96au_pkg::WORD_W'(1)) : a;
        b_mag = b_neg ? (~b + s96au_pkg::WORD_W'(1)) : b;
        b_dbl = {b_mag[s96au_pkg::WORD_W-2:0], 1'b0};
    end

    // Add, subtract and shifts; shifts of 96 or more fall out as zero
    always_comb begin
        unique case (cmd)
            s96au_pkg::CMD_ADD: simple_next = a + b;
            s96au_pkg::CMD_SUB: simple_next = a - b;
            s96au_pkg::CMD_SHL: simple_next = a << shamt;
            s96au_pkg::CMD_SHR: simple_next = a >> shamt;
            default:            simple_next = '0;
        endcase
    end

    // Multiplier operand select
    always_comb begin
        ctl_next.cmd  = cmd;
        ctl_next.flip = a_neg ^ b_neg;
        if (cmd == s96au_pkg::CMD_FMUL) begin
            x_next = a_mag;
            y_next = b_dbl;
        end else begin
            x_next = a;
            y_next = b;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctl_reg    <= ctl_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            simple_reg <= simple_next;
        end
    end

endmodule

/* src/s96au_mult.sv */
// ----------------------------------------------------------------------------
// s96au_mult
// Limb product stage: all nine 32x32 partial products, registered.
// ----------------------------------------------------------------------------
module s96au_mult (
    input  logic                   aclk,
    input  logic                   en,
    input  s96au_pkg::word_t       x,
    input  s96au_pkg::word_t       y,
    output s96au_pkg::prod_grid_t  prod_reg
);

    s96au_pkg::prod_grid_t prod_next;

    // Independent multipliers, one per limb pair
    always_comb begin
        for (int i = 0; i < s96au_pkg::NLIMB; i++) begin
            for (int j = 0; j < s96au_pkg::NLIMB; j++) begin
                prod_next[i][j] =
                    s96au_pkg::PROD_W'(x[i*s96au_pkg::LIMB_W +: s96au_pkg::LIMB_W]) *
                    s96au_pkg::PROD_W'(y[j*s96au_pkg::LIMB_W +: s96au_pkg::LIMB_W]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
        end
    end

endmodule

/* src/s96au_accum.sv */
// ----------------------------------------------------------------------------
// s96au_accum
// Partial product accumulation over two stages: column sums first, then the
// column carries, giving the wrapped product or the fractional product.
// ----------------------------------------------------------------------------
module s96au_accum (
    input  logic                   aclk,
    input  logic                   en_col,
    input  logic                   en_fin,
    input  s96au_pkg::prod_grid_t  prod,
    input  logic                   is_fmul,
    output s96au_pkg::word_t       prod_res_reg
);

    // Column stage
    logic [63:0] mul_up_next,  mul_up_reg;
    logic [31:0] mul_lo_next,  mul_lo_reg;
    logic [34:0] s_lo_next,    s_lo_reg;
    logic [34:0] s_mid_next,   s_mid_reg;
    logic [63:0] s_hi_next,    s_hi_reg;
    logic [34:0] up_top;

    // Carry stage
    logic [35:0]      s_mid_full;
    logic [63:0]      s_hi_full;
    s96au_pkg::word_t prod_res_next;

    // Wrapped product: low limb plus the two upper columns
    always_comb begin
        up_top = 35'(prod[0][2][31:0]) + 35'(prod[1][1][31:0]) + 35'(prod[2][0][31:0]);
        mul_lo_next = prod[0][0][31:0];
        mul_up_next = {32'd0, prod[0][0][63:32]} + prod[0][1] + prod[1][0]
                    + {up_top[31:0], 32'd0};
    end

    // Fractional product: only the eight upper partial products
    always_comb begin
        s_lo_next  = 35'(prod[0][1][63:32]) + 35'(prod[1][0][63:32])
                   + 35'(prod[0][2][31:0])  + 35'(prod[1][1][31:0])
                   + 35'(prod[2][0][31:0]);
        s_mid_next = 35'(prod[0][2][63:32]) + 35'(prod[1][1][63:32])
                   + 35'(prod[2][0][63:32]) + 35'(prod[1][2][31:0])
                   + 35'(prod[2][1][31:0]);
        s_hi_next  = prod[2][2] + 64'(prod[1][2][63:32]) + 64'(prod[2][1][63:32]);
    end

    // Column carries and product select
    always_comb begin
        s_mid_full = 36'(s_mid_reg) + 36'(s_lo_reg[34:32]);
        s_hi_full  = s_hi_reg + 64'(s_mid_full[35:32]);
        if (is_fmul) begin
            prod_res_next = {s_hi_full, s_mid_full[31:0]};
        end else begin
            prod_res_next = {mul_up_reg, mul_lo_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (en_col) begin
            mul_up_reg <= mul_up_next;
            mul_lo_reg <= mul_lo_next;
            s_lo_reg   <= s_lo_next;
            s_mid_reg  <= s_mid_next;
            s_hi_reg   <= s_hi_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_fin) begin
            prod_res_reg <= prod_res_next;
        end
    end

endmodule

/* src/signed_96bit_arith_unit.sv */
// ----------------------------------------------------------------------------
// signed_96bit_arith_unit
// 96-bit two's complement add, subtract, multiply, fractional multiply and
// logical shifts on a valid/ready stream.
// ----------------------------------------------------------------------------
// Fully pipelined: one item is accepted per cycle unless a stalled result has
// filled every stage; an item passes the input register, operand preparation,
// limb products, column sums, column carries and output register. The latency
// is set by the multiply path: nine 32x32 multipliers feed a two-stage
// accumulator, and the fractional multiply's sign is restored in the output
// stage. Add, subtract and shifts travel the same pipeline so results leave
// in order. Each stage holds its item while the next is full, so a stalled
// result still lets the stages behind it fill.
// ----------------------------------------------------------------------------
module signed_96bit_arith_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [2:0]          s_command,
    input  logic signed [31:0]  s_a_upper,
    input  logic [63:0]         s_a_lower,
    input  logic signed [31:0]  s_b_upper,
    input  logic [63:0]         s_b_lower,
    input  logic [7:0]          s_shift_amount,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [31:0]  m_result_upper,
    output logic [63:0]         m_result_lower
);

    localparam int unsigned NSTAGE = 6;

    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] valid_next;
    logic [NSTAGE-1:0] stage_rdy;

    // Input register
    s96au_pkg::cmd_t  cmd_in_reg;
    s96au_pkg::word_t a_in_reg;
    s96au_pkg::word_t b_in_reg;
    logic [7:0]       sh_in_reg;

    // Side band carried alongside the multiplier stages
    s96au_pkg::ctl_t  ctl1, ctl2_reg, ctl3_reg, ctl4_reg;
    s96au_pkg::word_t simple1, simple2_reg, simple3_reg, simple4_reg;

    s96au_pkg::word_t      x1, y1;
    s96au_pkg::prod_grid_t prod2;
    s96au_pkg::word_t      prod4;

    s96au_pkg::word_t result_next;
    s96au_pkg::word_t result_reg;

    // A stage takes a new item when empty or when its item moves on
    always_comb begin
        stage_rdy[NSTAGE-1] = !valid_reg[NSTAGE-1] || m_ready;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            stage_rdy[k] = !valid_reg[k] || stage_rdy[k+1];
        end
        valid_next[0] = stage_rdy[0] ? s_valid : valid_reg[0];
        for (int k = 1; k < NSTAGE; k++) begin
            valid_next[k] = stage_rdy[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Item capture
    always_ff @(posedge aclk) begin
        if (stage_rdy[0]) begin
            cmd_in_reg <= s96au_pkg::cmd_t'(s_command);
            a_in_reg   <= {s_a_upper, s_a_lower};
            b_in_reg   <= {s_b_upper, s_b_lower};
            sh_in_reg  <= s_shift_amount;
        end
    end

    s96au_prep u_prep (
        .aclk       (aclk),
        .en         (stage_rdy[1]),
        .cmd        (cmd_in_reg),
        .a          (a_in_reg),
        .b          (b_in_reg),
        .shamt      (sh_in_reg),
        .ctl_reg    (ctl1),
        .x_reg      (x1),
        .y_reg      (y1),
        .simple_reg (simple1)
    );

    s96au_mult u_mult (
        .aclk     (aclk),
        .en       (stage_rdy[2]),
        .x        (x1),
        .y        (y1),
        .prod_reg (prod2)
    );

    s96au_accum u_accum (
        .aclk         (aclk),
        .en_col       (stage_rdy[3]),
        .en_fin       (stage_rdy[4]),
        .prod         (prod2),
        .is_fmul      (ctl3_reg.cmd == s96au_pkg::CMD_FMUL),
        .prod_res_reg (prod4)
    );

    // Side band pipeline
    always_ff @(posedge aclk) begin
        if (stage_rdy[2]) begin
            ctl2_reg    <= ctl1;
            simple2_reg <= simple1;
        end
        if (stage_rdy[3]) begin
            ctl3_reg    <= ctl2_reg;
            simple3_reg <= simple2_reg;
        end
        if (stage_rdy[4]) begin
            ctl4_reg    <= ctl3_reg;
            simple4_reg <= simple3_reg;
        end
    end

    // Final select; fractional product takes back the sign
    always_comb begin
        priority if (ctl4_reg.cmd == s96au_pkg::CMD_FMUL) begin
            result_next = ctl4_reg.flip ? (~prod4 + s96au_pkg::WORD_W'(1)) : prod4;
        end else if (ctl4_reg.cmd == s96au_pkg::CMD_MUL) begin
            result_next = prod4;
        end else begin
            result_next = simple4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_rdy[NSTAGE-1]) begin
            result_reg <= result_next;
        end
    end

    assign s_ready        = stage_rdy[0];
    assign m_valid        = valid_reg[NSTAGE-1];
    assign m_result_upper = result_reg[95:64];
    assign m_result_lower = result_reg[63:0];

endmodule

/* verif/tb_signed_96bit_arith_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_signed_96bit_arith_unit
// Self-checking bench for the 96-bit arithmetic unit. A directed set covers
// operand extremes, every command, the unused command codes and the shift
// boundaries. It is followed by random items with random idle bursts on
// both handshakes. Every accepted item is run through a bit-exact predictor,
// and each result is compared in order against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_signed_96bit_arith_unit;

    // Command codes that the package leaves unnamed; these give a zero result
    localparam logic [2:0] CMD_RSVD6 = 3'd6;
    localparam logic [2:0] CMD_RSVD7 = 3'd7;

    localparam int unsigned PIPE_DEPTH   = 6;
    localparam int unsigned SHIFT_CLEAR  = 96;
    localparam int unsigned MAX_SHOWN    = 10;
    localparam int unsigned RANDOM_ITEMS = 600;
    localparam int unsigned QUIET_TAIL   = 100;
    localparam int unsigned PHASE_LEN    = 50;
    localparam int unsigned TIMEOUT_NS   = 5_000_000;

    localparam logic [63:0] LIMB_MASK = 64'h0000_0000_FFFF_FFFF;

    localparam s96au_pkg::word_t W_ZERO = '0;
    localparam s96au_pkg::word_t W_ONE  = 96'd1;
    localparam s96au_pkg::word_t W_ONES = '1;
    localparam s96au_pkg::word_t W_MAX  = {1'b0, {95{1'b1}}};
    localparam s96au_pkg::word_t W_MIN  = {1'b1, {95{1'b0}}};

    typedef struct {
        logic [31:0] upper;
        logic [63:0] lower;
    } result_t;

    // Predicts each operation and holds the results still owed by the block
    class arith_checker;
        result_t expected_q[$];
        int unsigned fail_count;

        function new();
            fail_count = 0;
        endfunction

        function s96au_pkg::word_t compute_result(logic [2:0] cmd, s96au_pkg::word_t a,
                                                  s96au_pkg::word_t b, logic [7:0] sh);
            s96au_pkg::word_t r;
            s96au_pkg::word_t m;
            s96au_pkg::word_t n;
            logic        flip;
            logic [63:0] a0, a1, a2, b0, b1, b2;
            logic [63:0] q1, q2, q3, q4, q5, q6, q7, q8;
            logic [63:0] s_lo, s_mid, s_hi;
            r = W_ZERO;
            case (cmd)
                s96au_pkg::CMD_ADD: r = a + b;
                s96au_pkg::CMD_SUB: r = a - b;
                s96au_pkg::CMD_MUL: r = a * b;
                s96au_pkg::CMD_FMUL: begin
                    // magnitudes; most negative stays 2^95, doubled b wraps
                    flip = a[95] ^ b[95];
                    m = a[95] ? W_ZERO - a : a;
                    n = b[95] ? W_ZERO - b : b;
                    n = n + n;
                    a2 = {32'd0, m[95:64]};
                    a1 = {32'd0, m[63:32]};
                    a0 = {32'd0, m[31:0]};
                    b2 = {32'd0, n[95:64]};
                    b1 = {32'd0, n[63:32]};
                    b0 = {32'd0, n[31:0]};
                    q1 = a2 * b2;
                    q2 = a2 * b1;
                    q3 = a2 * b0;
                    q4 = a1 * b2;
                    q5 = a1 * b1;
                    q6 = a1 * b0;
                    q7 = a0 * b2;
                    q8 = a0 * b1;
                    // upper eight partial products only, column carries
                    s_lo  = (q8 >> 32) + (q6 >> 32) + (q7 & LIMB_MASK)
                          + (q5 & LIMB_MASK) + (q3 & LIMB_MASK);
                    s_mid = (q7 >> 32) + (q5 >> 32) + (q3 >> 32)
                          + (q4 & LIMB_MASK) + (q2 & LIMB_MASK);
                    s_hi  = q1 + (q4 >> 32) + (q2 >> 32);
                    s_mid = s_mid + (s_lo >> 32);
                    s_hi  = s_hi + (s_mid >> 32);
                    r = {s_hi, s_mid[31:0]};
                    if (flip) begin
                        r = W_ZERO - r;
                    end
                end
                s96au_pkg::CMD_SHL: r = (sh < SHIFT_CLEAR) ? (a << sh) : W_ZERO;
                s96au_pkg::CMD_SHR: r = (sh < SHIFT_CLEAR) ? (a >> sh) : W_ZERO;
                default: r = W_ZERO;
            endcase
            return r;
        endfunction

        function void note_operation(logic [2:0] cmd, s96au_pkg::word_t a,
                                     s96au_pkg::word_t b, logic [7:0] sh);
            s96au_pkg::word_t r;
            result_t e;
            r = compute_result(cmd, a, b, sh);
            e.upper = r[95:64];
            e.lower = r[63:0];
            expected_q.push_back(e);
        endfunction

        function void check_result(logic [31:0] upper, logic [63:0] lower);
            result_t e;
            if (expected_q.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_SHOWN) begin
                    $display("ERROR %0t: unexpected result upper=%h lower=%h",
                             $realtime, upper, lower);
                end
                return;
            end
            e = expected_q.pop_front();
            if (upper !== e.upper || lower !== e.lower) begin
                fail_count++;
                if (fail_count <= MAX_SHOWN) begin
                    $display("ERROR %0t: upper exp %h got %h, lower exp %h got %h",
                             $realtime, e.upper, upper, e.lower, lower);
                end
            end
        endfunction

        function int unsigned outstanding();
            return expected_q.size();
        endfunction
    endclass

    logic               aclk           = 1'b0;
    logic               aresetn        = 1'b0;
    logic               s_valid        = 1'b0;
    logic               s_ready;
    logic [2:0]         s_command      = s96au_pkg::CMD_ADD;
    logic signed [31:0] s_a_upper      = '0;
    logic [63:0]        s_a_lower      = '0;
    logic signed [31:0] s_b_upper      = '0;
    logic [63:0]        s_b_lower      = '0;
    logic [7:0]         s_shift_amount = '0;
    logic               m_valid;
    logic               m_ready        = 1'b0;
    logic signed [31:0] m_result_upper;
    logic [63:0]        m_result_lower;

    logic src_idle  = 1'b1;
    logic sink_idle = 1'b1;

    arith_checker results = new();

    always #5 aclk = ~aclk;

    signed_96bit_arith_unit u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_a_upper      (s_a_upper),
        .s_a_lower      (s_a_lower),
        .s_b_upper      (s_b_upper),
        .s_b_lower      (s_b_lower),
        .s_shift_amount (s_shift_amount),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_upper (m_result_upper),
        .m_result_lower (m_result_lower)
    );

    // Watch both handshakes at the rising edge
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            results.note_operation(s_command, {s_a_upper, s_a_lower},
                                   {s_b_upper, s_b_lower}, s_shift_amount);
        end
        if (aresetn && m_valid && m_ready) begin
            results.check_result(m_result_upper, m_result_lower);
        end
    end

    // Result side: ready with random stall bursts
    initial begin
        forever begin
            @(negedge aclk);
            if (aresetn && sink_idle && $urandom_range(0, 5) == 0) begin
                m_ready = 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge aclk);
            end
            m_ready = 1'b1;
        end
    end

    // Present one item, hold it until accepted; entered and left at a falling edge
    task automatic send_item(input logic [2:0] cmd, input s96au_pkg::word_t a,
                             input s96au_pkg::word_t b, input logic [7:0] sh);
        if (src_idle && $urandom_range(0, 4) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge aclk);
        end
        s_valid        = 1'b1;
        s_command      = cmd;
        s_a_upper      = a[95:64];
        s_a_lower      = a[63:0];
        s_b_upper      = b[95:64];
        s_b_lower      = b[63:0];
        s_shift_amount = sh;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Mix of edge values, small magnitudes and full-width random patterns
    function automatic s96au_pkg::word_t pick_operand();
        s96au_pkg::word_t v;
        v = {$urandom, $urandom, $urandom};
        case ($urandom_range(0, 9))
            0: v = W_ZERO;
            1: v = W_ONES;
            2: v = W_MAX;
            3: v = W_MIN;
            4: v = {{64{v[95]}}, v[31:0]};
            5: v = {{32{v[95]}}, v[63:0]};
            default: ;
        endcase
        return v;
    endfunction

    // Stimulus and end of run
    initial begin
        int unsigned k;
        logic [2:0]  cmd;
        logic [7:0]  sh;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: extremes, every command, shift boundaries, unused codes
        send_item(s96au_pkg::CMD_ADD,  W_MAX,  W_ONE,  8'd255);
        send_item(s96au_pkg::CMD_ADD,  W_ONES, W_ONES, 8'd0);
        send_item(s96au_pkg::CMD_ADD,  W_MIN,  W_MIN,  8'd0);
        send_item(s96au_pkg::CMD_SUB,  W_ZERO, W_MIN,  8'd0);
        send_item(s96au_pkg::CMD_SUB,  W_MIN,  W_ONE,  8'd0);
        send_item(s96au_pkg::CMD_SUB,  W_ZERO, W_ONES, 8'd255);
        send_item(s96au_pkg::CMD_MUL,  W_MAX,  W_MAX,  8'd0);
        send_item(s96au_pkg::CMD_MUL,  W_MIN,  W_ONES, 8'd0);
        send_item(s96au_pkg::CMD_MUL,  W_ONES, W_ONES, 8'd0);
        send_item(s96au_pkg::CMD_MUL,  {32'd1, 64'hFFFF_FFFF_FFFF_FFFF},
                                       {32'd1, 64'hFFFF_FFFF_FFFF_FFFF}, 8'd0);
        send_item(s96au_pkg::CMD_FMUL, W_MAX,  W_MAX,  8'd0);
        // most negative b: its doubled magnitude wraps to zero
        send_item(s96au_pkg::CMD_FMUL, W_MIN,  W_MIN,  8'd0);
        send_item(s96au_pkg::CMD_FMUL, W_MAX,  W_MIN,  8'd0);
        send_item(s96au_pkg::CMD_FMUL, W_ONES, W_MAX,  8'd0);
        send_item(s96au_pkg::CMD_FMUL, W_MIN,  W_ONES, 8'd0);
        send_item(s96au_pkg::CMD_FMUL, W_ZERO, W_MAX,  8'd255);
        send_item(s96au_pkg::CMD_SHL,  W_ONES, W_ONES, 8'd0);
        send_item(s96au_pkg::CMD_SHL,  W_ONES, W_ZERO, 8'd63);
        send_item(s96au_pkg::CMD_SHL,  W_ONES, W_ZERO, 8'd64);
        send_item(s96au_pkg::CMD_SHL,  W_ONES, W_ZERO, 8'd95);
        send_item(s96au_pkg::CMD_SHL,  W_ONES, W_ZERO, 8'd96);
        send_item(s96au_pkg::CMD_SHR,  W_ONES, W_ONES, 8'd1);
        send_item(s96au_pkg::CMD_SHR,  W_MIN,  W_ONES, 8'd64);
        send_item(s96au_pkg::CMD_SHR,  W_ONES, W_ZERO, 8'd255);
        send_item(CMD_RSVD6, W_ONES, W_ONES, 8'd255);
        send_item(CMD_RSVD7, W_MAX,  W_MIN,  8'd7);

        // random phases; idling on or off per phase, none in the tail
        for (k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % PHASE_LEN == 0) begin
                src_idle  = (k < RANDOM_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
                sink_idle = (k < RANDOM_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 24) == 0) begin
                cmd = $urandom_range(0, 1) ? CMD_RSVD6 : CMD_RSVD7;
            end else begin
                cmd = 3'($urandom_range(s96au_pkg::CMD_ADD, s96au_pkg::CMD_SHR));
            end
            if ($urandom_range(0, 3) == 0) begin
                sh = 8'($urandom_range(0, 255));
            end else begin
                sh = 8'($urandom_range(0, SHIFT_CLEAR + 1));
            end
            send_item(cmd, pick_operand(), pick_operand(), sh);
        end
        s_valid = 1'b0;

        // drain, then allow for any stray late result
        while (results.outstanding() != 0) @(posedge aclk);
        repeat (4 * PIPE_DEPTH) @(posedge aclk);

        if (results.fail_count + results.outstanding() == 0) begin
            $display("** signed_96bit_arith_unit: PASSED **");
        end else begin
            $display("** signed_96bit_arith_unit: FAILED **");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("ERROR: timeout with %0d results outstanding", results.outstanding());
        $display("** signed_96bit_arith_unit: FAILED **");
        $finish;
    end

endmodule
